@@ sv/fcu_pkg.sv @@
// Package for the fly camera update block: types, constants and tables.
package fcu_pkg;

    localparam int PosFracBits = 16;
    localparam int VecFracBits = 14;
    localparam int CordicSteps = 18;

    localparam logic [1:0] CMD_MOVE = 2'd0;
    localparam logic [1:0] CMD_LOOK = 2'd1;
    localparam logic [1:0] CMD_ZOOM = 2'd2;

    localparam logic [2:0] DIR_FWD   = 3'd0;
    localparam logic [2:0] DIR_BACK  = 3'd1;
    localparam logic [2:0] DIR_LEFT  = 3'd2;
    localparam logic [2:0] DIR_RIGHT = 3'd3;
    localparam logic [2:0] DIR_UP    = 3'd4;
    localparam logic [2:0] DIR_DOWN  = 3'd5;

    localparam logic [2:0] REG_SPEED = 3'd0;
    localparam logic [2:0] REG_SENS  = 3'd1;
    localparam logic [2:0] REG_WUX   = 3'd2;
    localparam logic [2:0] REG_WUY   = 3'd3;
    localparam logic [2:0] REG_WUZ   = 3'd4;
    localparam logic [2:0] REG_SX    = 3'd5;
    localparam logic [2:0] REG_SY    = 3'd6;
    localparam logic [2:0] REG_SZ    = 3'd7;

    localparam logic signed [39:0] Turn     = 40'sd23592960;
    localparam logic signed [39:0] HalfTurn = 40'sd11796480;
    localparam logic signed [39:0] Quarter  = 40'sd5898240;
    localparam logic signed [39:0] CordicGain = 40'sd652032874;

    function automatic logic signed [31:0] atan_deg(input logic [4:0] i);
        logic signed [31:0] r;
        unique case (i)
            5'd0: r = 32'sd2949120;
            5'd1: r = 32'sd1740967;
            5'd2: r = 32'sd919879;
            5'd3: r = 32'sd466945;
            5'd4: r = 32'sd234379;
            5'd5: r = 32'sd117304;
            5'd6: r = 32'sd58666;
            5'd7: r = 32'sd29335;
            5'd8: r = 32'sd14668;
            5'd9: r = 32'sd7334;
            5'd10: r = 32'sd3667;
            5'd11: r = 32'sd1833;
            5'd12: r = 32'sd917;
            5'd13: r = 32'sd458;
            5'd14: r = 32'sd229;
            5'd15: r = 32'sd115;
            5'd16: r = 32'sd57;
            5'd17: r = 32'sd29;
            default: r = 32'sd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sh07FFFFFFF) r = 32'sh7FFFFFFF;
        else if (v < -34'sh080000000) r = 32'sh80000000;
        else r = v[31:0];
        return r;
    endfunction

    typedef struct packed {
        logic                start;
        logic signed [31:0]  angle;
    } t_cordic_req;

    typedef struct packed {
        logic                done;
        logic signed [39:0]  sin_q30;
        logic signed [39:0]  cos_q30;
    } t_cordic_rsp;

    typedef struct packed {
        logic                start;
        logic signed [63:0]  c0;
        logic signed [63:0]  c1;
        logic signed [63:0]  c2;
    } t_norm_req;

    typedef struct packed {
        logic                done;
        logic signed [15:0]  o0;
        logic signed [15:0]  o1;
        logic signed [15:0]  o2;
    } t_norm_rsp;

endpackage

@@ sv/fly_camera_update.sv @@
// Top level of the fly camera update block: command sequencer and state registers.
//  channel | valid     | stall     | payload
//  in      | i_valid   | o_stall   | i_command .. i_clamp_pitch
//  out     | o_valid   | i_stall   | o_pos_* .. o_zoom_out
//  config  | i_cfg_we  | -         | i_cfg_index, i_cfg_data
// Move items run a multiply and a step per axis before the output, zoom items a
// clamp; hold commands and no-op moves go to it directly. Look items run two CORDIC
// passes and three normalisations, each using the 48-step divider. Reset rebuilds
// the vectors the same way; no item is taken until that is done. Stall on out holds
// the result.
module fly_camera_update
    import fcu_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_command,
    input  logic [2:0]         i_direction,
    input  logic [15:0]        i_delta_time,
    input  logic signed [15:0] i_x_offset,
    input  logic signed [15:0] i_y_offset,
    input  logic               i_clamp_pitch,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [31:0] o_pos_z,
    output logic signed [15:0] o_front_x,
    output logic signed [15:0] o_front_y,
    output logic signed [15:0] o_front_z,
    output logic signed [15:0] o_cam_up_x,
    output logic signed [15:0] o_cam_up_y,
    output logic signed [15:0] o_cam_up_z,
    output logic signed [31:0] o_yaw_out,
    output logic signed [31:0] o_pitch_out,
    output logic [21:0]        o_zoom_out,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    typedef enum logic [12:0] {
        S_INIT  = 13'b0000000000001,
        S_IDLE  = 13'b0000000000010,
        S_MUL   = 13'b0000000000100,
        S_STEP  = 13'b0000000001000,
        S_LOOK  = 13'b0000000010000,
        S_CY    = 13'b0000000100000,
        S_CP    = 13'b0000001000000,
        S_FMUL  = 13'b0000010000000,
        S_NF    = 13'b0000100000000,
        S_NR    = 13'b0001000000000,
        S_NU    = 13'b0010000000000,
        S_ZOOM  = 13'b0100000000000,
        S_OUT   = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;
    logic [15:0]        r_speed, r_sens;
    logic signed [15:0] r_wu [3];
    logic signed [31:0] r_start [3];
    logic signed [31:0] r_pos [3];
    logic signed [31:0] n_pos [3];
    logic signed [31:0] r_yaw, n_yaw, r_pitch, n_pitch;
    logic [21:0]        r_zoom, n_zoom;
    logic signed [15:0] r_f [3];
    logic signed [15:0] n_f [3];
    logic signed [15:0] r_r [3];
    logic signed [15:0] n_r [3];
    logic signed [15:0] r_u [3];
    logic signed [15:0] n_u [3];
    logic [2:0]         r_dir, n_dir;
    logic [15:0]        r_dt, n_dt;
    logic signed [15:0] r_xo, n_xo, r_yo, n_yo;
    logic               r_clamp, n_clamp;
    logic [31:0]        r_vel, n_vel;
    logic [1:0]         r_k, n_k;
    logic               r_go, n_go;
    logic signed [39:0] r_sy, n_sy, r_cy, n_cy;
    logic signed [63:0] r_v [3];
    logic signed [63:0] n_v [3];
    logic               r_ov, n_ov;

    t_cordic_req cq;
    t_cordic_rsp cs;
    t_norm_req   nq;
    t_norm_rsp   ns;

    fcu_cordic u_cordic (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(cq), .o_rsp(cs));
    fcu_norm   u_norm   (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(nq), .o_rsp(ns));

    logic signed [15:0] vc;
    logic signed [49:0] prod;
    logic signed [33:0] d, psum, dx, dy, ysum, psum2;
    logic signed [33:0] z;
    logic signed [31:0] lim;

    always_comb begin
        lim = 32'sd5832704;
        vc = (r_dir < DIR_LEFT) ? r_f[r_k] : ((r_dir < DIR_UP) ? r_r[r_k] : r_u[r_k]);
        prod = 50'(vc) * $signed({1'b0, r_vel});
        d = 34'((prod + 50'sd131072) >>> 18);
        psum = (r_dir == DIR_BACK || r_dir == DIR_LEFT || r_dir == DIR_DOWN)
            ? 34'(r_pos[r_k]) - d : 34'(r_pos[r_k]) + d;
        dx = 34'((34'(r_xo) * $signed({1'b0, r_sens}) + 34'sd8) >>> 4);
        dy = 34'((34'(r_yo) * $signed({1'b0, r_sens}) + 34'sd8) >>> 4);
        ysum = 34'(r_yaw) + dx;
        psum2 = 34'(r_pitch) + dy;
        z = 34'({12'd0, r_zoom}) - (34'(r_yo) <<< 12);

        n_state = r_state;
        n_pos = r_pos;
        n_yaw = r_yaw;
        n_pitch = r_pitch;
        n_zoom = r_zoom;
        n_f = r_f;
        n_r = r_r;
        n_u = r_u;
        n_dir = r_dir;
        n_dt = r_dt;
        n_xo = r_xo;
        n_yo = r_yo;
        n_clamp = r_clamp;
        n_vel = r_vel;
        n_k = r_k;
        n_go = 1'b0;
        n_sy = r_sy;
        n_cy = r_cy;
        n_v = r_v;
        n_ov = r_ov;
        cq.start = 1'b0;
        cq.angle = r_yaw;
        nq.start = 1'b0;
        nq.c0 = r_v[0];
        nq.c1 = r_v[1];
        nq.c2 = r_v[2];

        unique case (r_state)
            S_INIT: begin
                n_pos = r_start;
                n_yaw = -32'sd5898240;
                n_pitch = '0;
                n_zoom = 22'd2949120;
                n_go = 1'b1;
                n_ov = 1'b0;
                n_state = S_CY;
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_dir = i_direction;
                    n_dt = i_delta_time;
                    n_xo = i_x_offset;
                    n_yo = i_y_offset;
                    n_clamp = i_clamp_pitch;
                    n_k = '0;
                    n_ov = 1'b1;
                    unique case (i_command)
                        CMD_MOVE: n_state = (i_direction <= DIR_DOWN) ? S_MUL : S_OUT;
                        CMD_LOOK: n_state = S_LOOK;
                        CMD_ZOOM: n_state = S_ZOOM;
                        default:  n_state = S_OUT;
                    endcase
                end
            end
            S_MUL: begin
                n_vel = r_speed * r_dt;
                n_state = S_STEP;
            end
            S_STEP: begin
                n_pos[r_k] = sat32(psum);
                n_k = r_k + 2'd1;
                if (r_k == 2'd2) n_state = S_OUT;
            end
            S_LOOK: begin
                n_yaw = sat32(ysum);
                n_pitch = sat32(psum2);
                if (r_clamp) begin
                    if (sat32(psum2) > lim) n_pitch = lim;
                    if (sat32(psum2) < -lim) n_pitch = -lim;
                end
                n_go = 1'b1;
                n_state = S_CY;
            end
            S_CY: begin
                cq.start = r_go;
                cq.angle = r_yaw;
                if (cs.done) begin
                    n_sy = cs.sin_q30;
                    n_cy = cs.cos_q30;
                    n_go = 1'b1;
                    n_state = S_CP;
                end
            end
            S_CP: begin
                cq.start = r_go;
                cq.angle = r_pitch;
                if (cs.done) begin
                    n_v[0] = 64'(32'(r_cy)) * 64'(32'(cs.cos_q30));
                    n_v[1] = 64'(cs.sin_q30) <<< 30;
                    n_v[2] = 64'(32'(r_sy)) * 64'(32'(cs.cos_q30));
                    n_go = 1'b1;
                    n_state = S_NF;
                end
            end
            S_NF: begin
                nq.start = r_go;
                if (ns.done) begin
                    n_f[0] = ns.o0;
                    n_f[1] = ns.o1;
                    n_f[2] = ns.o2;
                    n_v[0] = 64'(32'(ns.o1) * 32'(r_wu[2]) - 32'(ns.o2) * 32'(r_wu[1]));
                    n_v[1] = 64'(32'(ns.o2) * 32'(r_wu[0]) - 32'(ns.o0) * 32'(r_wu[2]));
                    n_v[2] = 64'(32'(ns.o0) * 32'(r_wu[1]) - 32'(ns.o1) * 32'(r_wu[0]));
                    n_go = 1'b1;
                    n_state = S_NR;
                end
            end
            S_NR: begin
                nq.start = r_go;
                if (ns.done) begin
                    n_r[0] = ns.o0;
                    n_r[1] = ns.o1;
                    n_r[2] = ns.o2;
                    n_v[0] = 64'(32'(ns.o1) * 32'(r_f[2]) - 32'(ns.o2) * 32'(r_f[1]));
                    n_v[1] = 64'(32'(ns.o2) * 32'(r_f[0]) - 32'(ns.o0) * 32'(r_f[2]));
                    n_v[2] = 64'(32'(ns.o0) * 32'(r_f[1]) - 32'(ns.o1) * 32'(r_f[0]));
                    n_go = 1'b1;
                    n_state = S_NU;
                end
            end
            S_NU: begin
                nq.start = r_go;
                if (ns.done) begin
                    n_u[0] = ns.o0;
                    n_u[1] = ns.o1;
                    n_u[2] = ns.o2;
                    n_state = r_ov ? S_OUT : S_IDLE;
                end
            end
            S_ZOOM: begin
                if (z < 34'sd65536) n_zoom = 22'd65536;
                else if (z > 34'sd2949120) n_zoom = 22'd2949120;
                else n_zoom = z[21:0];
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_speed <= 16'd640;
            r_sens <= 16'd6554;
            r_wu[0] <= '0;
            r_wu[1] <= 16'sd16384;
            r_wu[2] <= '0;
            r_start[0] <= '0;
            r_start[1] <= '0;
            r_start[2] <= '0;
            r_go <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go <= n_go;
            r_ov <= n_ov;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_SPEED: r_speed <= i_cfg_data[15:0];
                    REG_SENS:  r_sens <= i_cfg_data[15:0];
                    REG_WUX:   r_wu[0] <= i_cfg_data[15:0];
                    REG_WUY:   r_wu[1] <= i_cfg_data[15:0];
                    REG_WUZ:   r_wu[2] <= i_cfg_data[15:0];
                    REG_SX:    r_start[0] <= i_cfg_data;
                    REG_SY:    r_start[1] <= i_cfg_data;
                    REG_SZ:    r_start[2] <= i_cfg_data;
                    default:   r_speed <= r_speed;
                endcase
            end
        end
        r_pos <= n_pos;
        r_yaw <= n_yaw;
        r_pitch <= n_pitch;
        r_zoom <= n_zoom;
        r_f <= n_f;
        r_r <= n_r;
        r_u <= n_u;
        r_dir <= n_dir;
        r_dt <= n_dt;
        r_xo <= n_xo;
        r_yo <= n_yo;
        r_clamp <= n_clamp;
        r_vel <= n_vel;
        r_k <= n_k;
        r_sy <= n_sy;
        r_cy <= n_cy;
        r_v <= n_v;
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_pos_x = r_pos[0];
    assign o_pos_y = r_pos[1];
    assign o_pos_z = r_pos[2];
    assign o_front_x = r_f[0];
    assign o_front_y = r_f[1];
    assign o_front_z = r_f[2];
    assign o_cam_up_x = r_u[0];
    assign o_cam_up_y = r_u[1];
    assign o_cam_up_z = r_u[2];
    assign o_yaw_out = r_yaw;
    assign o_pitch_out = r_pitch;
    assign o_zoom_out = r_zoom;

endmodule

@@ sv/fcu_cordic.sv @@
// Iterative CORDIC: sine and cosine of an angle in degrees, one rotation a cycle.
module fcu_cordic
    import fcu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cordic_req i_req,
    output t_cordic_rsp o_rsp
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_ROT  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic signed [39:0] r_x, n_x, r_y, n_y, r_z, n_z;
    logic               r_neg, n_neg;
    logic [4:0]         r_i, n_i;

    logic signed [39:0] z0, z1, z2, sx, sy;

    always_comb begin
        z0 = 40'(i_req.angle) % Turn;
        if (z0 < 0) z0 = z0 + Turn;
        z1 = (z0 >= HalfTurn) ? z0 - Turn : z0;
        z2 = z1;
        sx = r_x >>> r_i;
        sy = r_y >>> r_i;
        n_state = r_state;
        n_x = r_x;
        n_y = r_y;
        n_z = r_z;
        n_neg = r_neg;
        n_i = r_i;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.start) begin
                    n_neg = 1'b0;
                    if (z1 > Quarter) begin
                        z2 = z1 - HalfTurn;
                        n_neg = 1'b1;
                    end else if (z1 < -Quarter) begin
                        z2 = z1 + HalfTurn;
                        n_neg = 1'b1;
                    end
                    n_z = z2;
                    n_x = CordicGain;
                    n_y = '0;
                    n_i = '0;
                    n_state = S_ROT;
                end
            end
            S_ROT: begin
                if (r_z >= 0) begin
                    n_x = r_x - sy;
                    n_y = r_y + sx;
                    n_z = r_z - 40'(atan_deg(r_i));
                end else begin
                    n_x = r_x + sy;
                    n_y = r_y - sx;
                    n_z = r_z + 40'(atan_deg(r_i));
                end
                n_i = r_i + 5'd1;
                if (r_i == 5'(CordicSteps - 1)) n_state = S_DONE;
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
        r_neg <= n_neg;
        r_i <= n_i;
    end

    assign o_rsp.done    = (r_state == S_DONE);
    assign o_rsp.cos_q30 = r_neg ? -r_x : r_x;
    assign o_rsp.sin_q30 = r_neg ? -r_y : r_y;

endmodule

@@ sv/fcu_norm.sv @@
// Vector normaliser: range scaling, bitwise square root and restoring divides.
module fcu_norm
    import fcu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_norm_req i_req,
    output t_norm_rsp o_rsp
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCALE = 7'b0000010,
        S_SQ    = 7'b0000100,
        S_SQRT  = 7'b0001000,
        S_DIVI  = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [63:0] r_a [3];
    logic [63:0] n_a [3];
    logic [2:0]  r_sgn, n_sgn;
    logic [63:0] r_sum, n_sum, r_root, n_root, r_bit, n_bit;
    logic [1:0]  r_k, n_k;
    logic [47:0] r_rem, n_rem, r_quo, n_quo;
    logic [5:0]  r_cnt, n_cnt;
    logic [15:0] r_o [3];
    logic [15:0] n_o [3];
    logic [2:0]  r_rb, n_rb;
    logic        r_shr, n_shr;
    logic        r_run, n_run;

    logic [63:0] m, ca0, ca1, ca2, sq, trial;
    logic [30:0] sqa;
    logic [61:0] sqp;
    logic [47:0] rs;

    always_comb begin
        ca0 = i_req.c0[63] ? 64'(-i_req.c0) : 64'(i_req.c0);
        ca1 = i_req.c1[63] ? 64'(-i_req.c1) : 64'(i_req.c1);
        ca2 = i_req.c2[63] ? 64'(-i_req.c2) : 64'(i_req.c2);
        m = r_a[0];
        if (r_a[1] > m) m = r_a[1];
        if (r_a[2] > m) m = r_a[2];
        sqa = r_a[r_k][30:0];
        sqp = sqa * sqa;
        sq = {2'b00, sqp};
        trial = r_root + r_bit;
        rs = {r_rem[46:0], r_quo[47]};
        n_state = r_state;
        n_a = r_a;
        n_sgn = r_sgn;
        n_sum = r_sum;
        n_root = r_root;
        n_bit = r_bit;
        n_k = r_k;
        n_rem = r_rem;
        n_quo = r_quo;
        n_cnt = r_cnt;
        n_o = r_o;
        n_rb = r_rb;
        n_shr = r_shr;
        n_run = r_run;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.start) begin
                    n_a[0] = ca0;
                    n_a[1] = ca1;
                    n_a[2] = ca2;
                    n_sgn = {i_req.c2[63], i_req.c1[63], i_req.c0[63]};
                    n_shr = 1'b0;
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                if (m == '0) begin
                    n_o[0] = '0;
                    n_o[1] = '0;
                    n_o[2] = '0;
                    n_state = S_DONE;
                end else if (m >= 64'h4000_0000) begin
                    // truncate one bit at a time, keep the last bit dropped for rounding
                    for (int j = 0; j < 3; j++) begin
                        n_a[j] = r_a[j] >> 1;
                        n_rb[j] = r_a[j][0];
                    end
                    n_shr = 1'b1;
                end else if (r_shr) begin
                    for (int j = 0; j < 3; j++) n_a[j] = r_a[j] + {63'd0, r_rb[j]};
                    n_shr = 1'b0;
                    n_k = '0;
                    n_sum = '0;
                    n_state = S_SQ;
                end else if (m < 64'h2000_0000) begin
                    for (int j = 0; j < 3; j++) n_a[j] = r_a[j] << 1;
                end else begin
                    n_k = '0;
                    n_sum = '0;
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                n_sum = r_sum + sq;
                n_k = r_k + 2'd1;
                if (r_k == 2'd2) begin
                    n_root = '0;
                    n_bit = 64'd1 << 62;
                    n_run = 1'b0;
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if (!r_run && r_bit > r_sum) begin
                    n_bit = r_bit >> 2;
                end else begin
                    n_run = 1'b1;
                    if (r_sum >= trial) begin
                        n_sum = r_sum - trial;
                        n_root = (r_root >> 1) + r_bit;
                    end else begin
                        n_root = r_root >> 1;
                    end
                    n_bit = r_bit >> 2;
                    if (r_bit == 64'd1) begin
                        n_k = '0;
                        n_state = S_DIVI;
                    end
                end
                if (r_bit == '0) begin
                    n_k = '0;
                    n_state = S_DIVI;
                end
            end
            S_DIVI: begin
                n_quo = 48'(r_a[r_k] << VecFracBits) + 48'(r_root >> 1);
                n_rem = '0;
                n_cnt = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_quo = {r_quo[46:0], 1'b0};
                n_rem = rs;
                if (rs >= r_root[47:0]) begin
                    n_rem = rs - r_root[47:0];
                    n_quo[0] = 1'b1;
                end
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd47) begin
                    n_o[r_k] = r_sgn[r_k] ? 16'(-n_quo) : n_quo[15:0];
                    n_k = r_k + 2'd1;
                    n_state = (r_k == 2'd2) ? S_DONE : S_DIVI;
                end
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_a <= n_a;
        r_sgn <= n_sgn;
        r_sum <= n_sum;
        r_root <= n_root;
        r_bit <= n_bit;
        r_k <= n_k;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_cnt <= n_cnt;
        r_o <= n_o;
        r_rb <= n_rb;
        r_shr <= n_shr;
        r_run <= n_run;
    end

    assign o_rsp.done = (r_state == S_DONE);
    assign o_rsp.o0 = r_o[0];
    assign o_rsp.o1 = r_o[1];
    assign o_rsp.o2 = r_o[2];

endmodule
